FILE: hw/rtl/complex_fir_peak_tracker_macros.svh
// assertion macros for the complex fir peak tracker
`ifndef COMPLEX_FIR_PEAK_TRACKER_MACROS_SVH
`define COMPLEX_FIR_PEAK_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define CFPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFPT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFPT_ASSERT(label, clk, rst, prop, msg)
`define CFPT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/cfpt_pkg.sv
// shared constants and types for the complex fir peak tracker
package cfpt_pkg;

  localparam int TAP_COUNT     = 8;
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_TAPS      = 8;
  localparam int SAMPLE_W      = 16;
  localparam int SEXT_SHIFT    = SAMPLE_W - SAMPLE_BITS;
  localparam int FRAC_BITS     = 15;
  localparam int FILT_BITS     = 20;
  localparam int PROD_BITS     = 2 * SAMPLE_W;
  localparam int ACC_BITS      = FILT_BITS + FRAC_BITS;
  localparam int SQ_BITS       = 2 * FILT_BITS;
  localparam int MAG_BITS      = 38;
  localparam int INDEX_BITS    = 32;
  localparam int FILL_BITS     = $clog2(TAP_COUNT + 1);
  localparam int STEP_BITS     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = $clog2(MAX_TAPS);
  localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [FILT_BITS-1:0] filt_t;
  typedef logic [MAG_BITS-1:0] mag_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MAC    = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_SQUARE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic mac;
    logic drain;
    logic square;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full_after;
    logic last_tap;
    logic slot_free;
  } status_t;

endpackage

FILE: hw/rtl/cfpt_if.sv
// request and result channels of the complex fir peak tracker
interface cfpt_in_if;
  logic              valid;
  logic              ready;
  logic              start_req;
  cfpt_pkg::sample_t sample_i;
  cfpt_pkg::sample_t sample_q;

  modport source(output valid, start_req, sample_i, sample_q, input ready);
  modport sink(input valid, start_req, sample_i, sample_q, output ready);
endinterface

interface cfpt_out_if;
  logic                                valid;
  logic                                ready;
  logic [cfpt_pkg::INDEX_BITS-1:0]     out_index;
  cfpt_pkg::filt_t                     filt_i;
  cfpt_pkg::filt_t                     filt_q;
  cfpt_pkg::mag_t                      mag_squared;
  cfpt_pkg::mag_t                      peak_mag_squared;

  modport source(output valid, out_index, filt_i, filt_q, mag_squared, peak_mag_squared,
                 input ready);
  modport sink(input valid, out_index, filt_i, filt_q, mag_squared, peak_mag_squared,
               output ready);
endinterface

FILE: hw/rtl/complex_fir_peak_tracker.sv
// Complex FIR with real Q1.15 taps and running peak of squared magnitude.
// I and Q share one coefficient set, written over APB at byte address 4*i
// and read back sign extended. A sample that leaves the window short of
// full is taken and gives no result. A sample that fills the window holds
// off the next request until the accept and the states MAC (a multiply per
// tap on the shared I and Q multiplier pair), DRAIN for the accumulator,
// SQUARE for the squares and EMIT for the magnitude sum, peak compare and
// output load are done. The output register holds one result, so a
// stalled result delays the next filtered sample by the stall.
module complex_fir_peak_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  cfpt_in_if.sink                              samples,
  cfpt_out_if.source                           results,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cfpt_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [cfpt_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [cfpt_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  cfpt_pkg::sample_t  taps_all [cfpt_pkg::MAX_TAPS];
  cfpt_pkg::sample_t  taps_use [cfpt_pkg::TAP_COUNT];
  cfpt_pkg::cmd_t     cmd;
  cfpt_pkg::status_t  status;
  logic               in_ready;

  always_comb begin
    for (int j = 0; j < cfpt_pkg::TAP_COUNT; j++) begin
      taps_use[j] = taps_all[j];
    end
  end

  assign samples.ready = in_ready;

  cfpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .taps    (taps_all)
  );

  cfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .start_req (samples.start_req),
    .sample_i  (samples.sample_i),
    .sample_q  (samples.sample_q),
    .taps      (taps_use),
    .results   (results)
  );

endmodule

FILE: hw/rtl/cfpt_regs.sv
// apb coefficient register file
module cfpt_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cfpt_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [cfpt_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [cfpt_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  output cfpt_pkg::sample_t                     taps [cfpt_pkg::MAX_TAPS]
);

  logic [cfpt_pkg::REG_IDX_BITS-1:0] idx;
  logic                              wr_en;

  assign idx    = paddr[cfpt_pkg::APB_ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = cfpt_pkg::APB_DATA_BITS'(taps[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < cfpt_pkg::MAX_TAPS; j++) begin
        taps[j] <= '0;
      end
    end else if (wr_en) begin
      taps[idx] <= cfpt_pkg::sample_t'(pwdata[cfpt_pkg::SAMPLE_W-1:0]);
    end
  end

endmodule

FILE: hw/rtl/cfpt_ctrl.sv
// controller state machine for the filter sequence
`include "complex_fir_peak_tracker_macros.svh"
module cfpt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfpt_pkg::status_t   status,
  output cfpt_pkg::cmd_t      cmd
);

  cfpt_pkg::state_t state;
  cfpt_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      cfpt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.full_after) begin
            state_next = cfpt_pkg::S_MAC;
          end
        end
      end
      cfpt_pkg::S_MAC: begin
        cmd.mac = 1'b1;
        if (status.last_tap) begin
          state_next = cfpt_pkg::S_DRAIN;
        end
      end
      cfpt_pkg::S_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = cfpt_pkg::S_SQUARE;
      end
      cfpt_pkg::S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = cfpt_pkg::S_EMIT;
      end
      cfpt_pkg::S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = cfpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cfpt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CFPT_ASSERT(a_load_dispatch, clk, rst, cmd.load |=> (state == cfpt_pkg::S_MAC) == $past(status.full_after), "filter start does not follow window fill")
  `CFPT_ASSERT(a_drain_after_last, clk, rst, $rose(state == cfpt_pkg::S_DRAIN) |-> $past(status.last_tap), "drain entered before last tap")

endmodule

FILE: hw/rtl/cfpt_datapath.sv
// window, shared multiply-accumulate, magnitude and peak datapath
`include "complex_fir_peak_tracker_macros.svh"
module cfpt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  cfpt_pkg::cmd_t       cmd,
  output cfpt_pkg::status_t    status,
  input  logic                 start_req,
  input  cfpt_pkg::sample_t    sample_i,
  input  cfpt_pkg::sample_t    sample_q,
  input  cfpt_pkg::sample_t    taps [cfpt_pkg::TAP_COUNT],
  cfpt_out_if.source           results
);

  cfpt_pkg::sample_t                       win_i [cfpt_pkg::TAP_COUNT];
  cfpt_pkg::sample_t                       win_q [cfpt_pkg::TAP_COUNT];
  cfpt_pkg::sample_t                       coef  [cfpt_pkg::TAP_COUNT];
  logic [cfpt_pkg::SAMPLE_W-1:0]           sh_i;
  logic [cfpt_pkg::SAMPLE_W-1:0]           sh_q;
  cfpt_pkg::sample_t                       ext_i;
  cfpt_pkg::sample_t                       ext_q;
  logic [cfpt_pkg::FILL_BITS-1:0]          fill;
  logic [cfpt_pkg::STEP_BITS-1:0]          step;
  logic signed [cfpt_pkg::PROD_BITS-1:0]   prod_i;
  logic signed [cfpt_pkg::PROD_BITS-1:0]   prod_q;
  logic signed [cfpt_pkg::ACC_BITS-1:0]    acc_i;
  logic signed [cfpt_pkg::ACC_BITS-1:0]    acc_q;
  cfpt_pkg::filt_t                         fi;
  cfpt_pkg::filt_t                         fq;
  logic signed [cfpt_pkg::SQ_BITS-1:0]     sqr_i;
  logic signed [cfpt_pkg::SQ_BITS-1:0]     sqr_q;
  cfpt_pkg::mag_t                          sq_i;
  cfpt_pkg::mag_t                          sq_q;
  cfpt_pkg::mag_t                          mag_sum;
  cfpt_pkg::mag_t                          peak;
  cfpt_pkg::mag_t                          peak_next;
  logic [cfpt_pkg::INDEX_BITS-1:0]         count;

  // sign extend from the active sample width
  assign sh_i  = sample_i << cfpt_pkg::SEXT_SHIFT;
  assign sh_q  = sample_q << cfpt_pkg::SEXT_SHIFT;
  assign ext_i = $signed(sh_i) >>> cfpt_pkg::SEXT_SHIFT;
  assign ext_q = $signed(sh_q) >>> cfpt_pkg::SEXT_SHIFT;

  // floor shift is the upper slice of the accumulator
  assign fi = acc_i[cfpt_pkg::ACC_BITS-1:cfpt_pkg::FRAC_BITS];
  assign fq = acc_q[cfpt_pkg::ACC_BITS-1:cfpt_pkg::FRAC_BITS];

  assign sqr_i     = cfpt_pkg::SQ_BITS'(fi * fi);
  assign sqr_q     = cfpt_pkg::SQ_BITS'(fq * fq);
  assign mag_sum   = sq_i + sq_q;
  assign peak_next = (mag_sum > peak) ? mag_sum : peak;

  assign status.full_after = start_req ? (cfpt_pkg::TAP_COUNT == 1)
                                       : (fill >= cfpt_pkg::FILL_BITS'(cfpt_pkg::TAP_COUNT - 1));
  assign status.last_tap   = (step == cfpt_pkg::STEP_BITS'(cfpt_pkg::TAP_COUNT - 1));
  assign status.slot_free  = !results.valid || results.ready;

  // window and coefficient copy rotate together so tap zero meets the oldest sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < cfpt_pkg::TAP_COUNT - 1; j++) begin
        win_i[j] <= win_i[j+1];
        win_q[j] <= win_q[j+1];
      end
      win_i[cfpt_pkg::TAP_COUNT-1] <= ext_i;
      win_q[cfpt_pkg::TAP_COUNT-1] <= ext_q;
      coef <= taps;
    end else if (cmd.mac) begin
      for (int j = 0; j < cfpt_pkg::TAP_COUNT - 1; j++) begin
        win_i[j] <= win_i[j+1];
        win_q[j] <= win_q[j+1];
        coef[j]  <= coef[j+1];
      end
      win_i[cfpt_pkg::TAP_COUNT-1] <= win_i[0];
      win_q[cfpt_pkg::TAP_COUNT-1] <= win_q[0];
      coef[cfpt_pkg::TAP_COUNT-1]  <= coef[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step   <= '0;
      prod_i <= '0;
      prod_q <= '0;
      acc_i  <= '0;
      acc_q  <= '0;
    end else if (cmd.mac) begin
      step   <= step + 1'b1;
      prod_i <= cfpt_pkg::PROD_BITS'(win_i[0] * coef[0]);
      prod_q <= cfpt_pkg::PROD_BITS'(win_q[0] * coef[0]);
      acc_i  <= acc_i + cfpt_pkg::ACC_BITS'(prod_i);
      acc_q  <= acc_q + cfpt_pkg::ACC_BITS'(prod_q);
    end else if (cmd.drain) begin
      acc_i  <= acc_i + cfpt_pkg::ACC_BITS'(prod_i);
      acc_q  <= acc_q + cfpt_pkg::ACC_BITS'(prod_q);
    end
    if (cmd.square) begin
      sq_i <= sqr_i[cfpt_pkg::MAG_BITS-1:0];
      sq_q <= sqr_q[cfpt_pkg::MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
      peak  <= '0;
    end else if (cmd.load) begin
      if (start_req) begin
        fill  <= cfpt_pkg::FILL_BITS'(1);
        count <= '0;
        peak  <= '0;
      end else if (fill < cfpt_pkg::FILL_BITS'(cfpt_pkg::TAP_COUNT)) begin
        fill <= fill + 1'b1;
      end
    end else if (cmd.emit) begin
      peak  <= peak_next;
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.out_index        <= count;
      results.filt_i           <= fi;
      results.filt_q           <= fq;
      results.mag_squared      <= mag_sum;
      results.peak_mag_squared <= peak_next;
    end
  end

  `CFPT_ASSERT(a_peak_covers_mag, clk, rst, results.valid |-> results.peak_mag_squared >= results.mag_squared, "peak below its own magnitude")
  `CFPT_ASSERT(a_fill_bounded, clk, rst, fill <= cfpt_pkg::FILL_BITS'(cfpt_pkg::TAP_COUNT), "fill count past tap count")
  `CFPT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !results.valid, "result pending after reset")

endmodule
